// ===== hw/rtl/trapezoid_move_time_macros.svh =====
// ----------------------------------------------------------------------------
// Trapezoid move time assertion macros
// Shorthand for the concurrent checks on the block's ports, sampled on clk
// and switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_MOVE_TIME_MACROS_SVH
`define TRAPEZOID_MOVE_TIME_MACROS_SVH

// Same-cycle implication.
`define TMT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Trapezoid move time package
// Widths, constants, register codes and stage payload types of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmt_pkg;

	localparam int COORD_BITS_DEF     = 24;
	localparam int TIME_FRAC_BITS_DEF = 10;

	localparam int RATE_W     = 16;
	localparam int DUR_W      = 24;
	localparam int EXTRA_W    = DUR_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int DIST_W      = 33;
	localparam int RAD_W       = 2 * DIST_W;
	localparam int DIST_SH     = 16;
	localparam int PATH_SAT_SH = RAD_W - DIST_SH;
	localparam int TIME_W      = 48;

	localparam int PROD_W  = 2 * RATE_W;
	localparam int ASUM_W  = RATE_W + 1;
	localparam int RHS0_W  = PROD_W + ASUM_W;
	localparam int PROD3_W = PROD_W + RATE_W;
	localparam int LHS_W   = DIST_W + PROD_W + 1;
	localparam int P2_W    = DIST_W + ASUM_W + 1;
	localparam int RHS_W   = RHS0_W + 8;
	localparam int SLR_W   = LHS_W + 1;
	localparam int NUMT_W  = P2_W + 20;
	localparam int NUMZ_W  = SLR_W + 10;
	localparam int DEN_W   = PROD3_W + 9;

	localparam int MS_PER_S    = 1000;
	localparam int MS_PER_S_SQ = 1000000;

	localparam logic [RATE_W-1:0] SPEED_RST = 16'd1000;
	localparam logic [RATE_W-1:0] ACCEL_RST = 16'd500;
	localparam logic [RATE_W-1:0] DECEL_RST = 16'd500;

	localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECEL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNLOAD = 3'd4;

	// Carried alongside the distance square root.
	typedef struct packed {
		logic                psat;
		logic [PROD_W-1:0]   a1a2;
		logic [ASUM_W-1:0]   asum;
		logic [RHS0_W-1:0]   rhs0;
		logic [PROD3_W-1:0]  a1a2v;
		logic                hand;
		logic [EXTRA_W-1:0]  extra;
	} dist_pay_t;

	// Carried alongside the divider.
	typedef struct packed {
		logic                is_tri;
		logic                tsat;
		logic [DIST_W-1:0]   plen;
		logic                hand;
		logic [EXTRA_W-1:0]  extra;
	} div_pay_t;

	// Carried alongside the triangular-case square root.
	typedef struct packed {
		logic                is_tri;
		logic [TIME_W-1:0]   trap_t;
		logic [DIST_W-1:0]   plen;
		logic                hand;
		logic [EXTRA_W-1:0]  extra;
	} tri_pay_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tmt_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One digit step of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tmt_sqrt_cell #(
	parameter int RW = 33,
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  logic [2*RW-1:0] x_in,
	input  logic [RW:0]     rem_in,
	input  logic [RW-1:0]   root_in,
	input  logic [PW-1:0]   pay_in,
	output logic            vld_s1,
	output logic [2*RW-1:0] x_s1,
	output logic [RW:0]     rem_s1,
	output logic [RW-1:0]   root_s1,
	output logic [PW-1:0]   pay_s1
);

	logic [RW+2:0] cand;
	logic [RW+2:0] trial;
	logic [RW+2:0] diff;
	logic          ge;

	// The next two radicand bits join the partial remainder; the trial
	// subtrahend is four times the root so far plus one.
	assign cand  = {rem_in, x_in[2*RW-1 -: 2]};
	assign trial = {1'b0, root_in, 2'b01};
	assign ge    = cand >= trial;
	assign diff  = cand - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= {x_in[2*RW-3:0], 2'b00};
			rem_s1  <= ge ? diff[RW:0] : cand[RW:0];
			root_s1 <= {root_in[RW-2:0], ge};
			pay_s1  <= pay_in;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tmt_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of a restoring division against a shifted divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tmt_div_cell #(
	parameter int NW = 80,
	parameter int DW = 57,
	parameter int QW = 64,
	parameter int SH = 0,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [NW-1:0] rem_in,
	input  logic [DW-1:0] den_in,
	input  logic [QW-1:0] quo_in,
	input  logic [PW-1:0] pay_in,
	output logic          vld_s1,
	output logic [NW-1:0] rem_s1,
	output logic [DW-1:0] den_s1,
	output logic [QW-1:0] quo_s1,
	output logic [PW-1:0] pay_s1
);

	localparam int EW = (NW > DW + SH) ? NW : DW + SH;

	logic [EW-1:0] rem_ext;
	logic [EW-1:0] den_sh;
	logic          ge;
	logic [QW-1:0] quo_nx;

	assign rem_ext = EW'(rem_in);
	assign den_sh  = EW'(den_in) << SH;
	assign ge      = rem_ext >= den_sh;

	always_comb begin
		quo_nx     = quo_in;
		quo_nx[SH] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= ge ? NW'(rem_ext - den_sh) : rem_in;
			den_s1 <= den_in;
			quo_s1 <= quo_nx;
			pay_s1 <= pay_in;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/trapezoid_move_time.sv =====
// ----------------------------------------------------------------------------
// Trapezoid move time
// Path length and travel time of a point-to-point move under a trapezoidal
// velocity profile, as a pipeline of square root and divider cells.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while in_stall is low. The pipeline
// is built of cell chains: 33 square root cells for the distance,
// 63 + 2 * TIME_FRAC_BITS divider cells and 32 + TIME_FRAC_BITS square root
// cells for the time, plus eleven arithmetic and buffer stages. A two-entry
// output buffer holds finished results; in_stall is raised only while it is
// full, and then the whole pipeline holds.
`default_nettype none

module trapezoid_move_time #(
	parameter int COORD_BITS     = tmt_pkg::COORD_BITS_DEF,
	parameter int TIME_FRAC_BITS = tmt_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [COORD_BITS-1:0]   from_x,
	input  logic signed [COORD_BITS-1:0]   from_y,
	input  logic signed [COORD_BITS-1:0]   from_z,
	input  logic signed [COORD_BITS-1:0]   to_x,
	input  logic signed [COORD_BITS-1:0]   to_y,
	input  logic signed [COORD_BITS-1:0]   to_z,
	input  logic                           with_handling,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tmt_pkg::TIME_W-1:0]     travel_time,
	output logic [tmt_pkg::DIST_W-1:0]     path_length,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tmt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmt_pkg::CFG_DATA_W-1:0] cfg_data
);

	import tmt_pkg::*;

	localparam int CB         = COORD_BITS;
	localparam int FB         = TIME_FRAC_BITS;
	localparam int SQ_W       = 2 * CB;
	localparam int SUM_W      = 2 * CB + 2;
	localparam int NUM_TRI_W  = NUMT_W + 2 * FB;
	localparam int NUM_TRAP_W = NUMZ_W + FB;
	localparam int NUM_W      = (NUM_TRI_W > NUM_TRAP_W) ? NUM_TRI_W : NUM_TRAP_W;
	localparam int QUO_W      = NUMT_W - 8 + 2 * FB;
	localparam int TRT_W      = (QUO_W + 1) / 2;
	localparam int TRAD_W     = 2 * TRT_W;
	localparam int CMP_W      = (NUM_W > DEN_W + TIME_W) ? NUM_W : DEN_W + TIME_W;
	localparam int ADD_W      = ((TIME_W > EXTRA_W + FB) ? TIME_W : EXTRA_W + FB) + 1;
	localparam int DPAY_W     = $bits(dist_pay_t);
	localparam int VPAY_W     = $bits(div_pay_t);
	localparam int TPAY_W     = $bits(tri_pay_t);

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [DIST_W-1:0] PATH_MAX = '1;
	localparam logic [1:0]        BUF_FULL = 2'd2;

	// Configuration registers.
	logic [RATE_W-1:0] speed_q, accel_q, decel_q;
	logic [DUR_W-1:0]  load_q, unload_q;

	// Pipeline control.
	logic adv;
	logic push, pop;
	logic [1:0] cnt_q;
	logic wr_q, rd_q;

	// Stage 1: coordinate differences.
	logic signed [CB-1:0] fa [3];
	logic signed [CB-1:0] ta [3];
	logic signed [CB:0]   dd [3];
	logic [CB-1:0]        ad [3];
	logic                 vld_s1;
	logic [CB-1:0]        ad_s1 [3];
	logic [RATE_W-1:0]    v_s1, a1_s1, a2_s1;
	logic                 hand_s1;
	logic [EXTRA_W-1:0]   extra_s1;

	// Stage 2: squares and rate products.
	logic                 vld_s2;
	logic [SQ_W-1:0]      sq_s2 [3];
	logic [PROD_W-1:0]    a1a2_s2, vsq_s2;
	logic [ASUM_W-1:0]    asum_s2;
	logic [RATE_W-1:0]    v_s2;
	logic                 hand_s2;
	logic [EXTRA_W-1:0]   extra_s2;

	// Stage 3: radicand of the distance.
	logic [SUM_W-1:0]     ssum;
	logic                 vld_s3;
	logic [RAD_W-1:0]     rad_s3;
	dist_pay_t            dpay_s3;

	// Distance square root chain.
	logic                 dc_vld  [DIST_W+1];
	logic [RAD_W-1:0]     dc_x    [DIST_W+1];
	logic [DIST_W:0]      dc_rem  [DIST_W+1];
	logic [DIST_W-1:0]    dc_root [DIST_W+1];
	logic [DPAY_W-1:0]    dc_pay  [DIST_W+1];
	dist_pay_t            dpo;
	logic [DIST_W-1:0]    plen;

	// Stages 4 to 8: profile selection, numerator and divisor.
	logic                 vld_s4;
	logic [LHS_W-1:0]     lhs_s4;
	logic [P2_W-1:0]      p2_s4;
	logic [RHS_W-1:0]     rhs_s4;
	logic [DIST_W-1:0]    dist_s4;
	logic [PROD_W-1:0]    a1a2_s4;
	logic [PROD3_W-1:0]   a1a2v_s4;
	logic                 hand_s4;
	logic [EXTRA_W-1:0]   extra_s4;

	logic                 vld_s5, tri_s5;
	logic [SLR_W-1:0]     slr_s5;
	logic [P2_W-1:0]      p2_s5;
	logic [PROD_W-1:0]    a1a2_s5;
	logic [PROD3_W-1:0]   a1a2v_s5;
	logic [DIST_W-1:0]    dist_s5;
	logic                 hand_s5;
	logic [EXTRA_W-1:0]   extra_s5;

	logic                 vld_s6, tri_s6;
	logic [NUMT_W-1:0]    numt_s6;
	logic [NUMZ_W-1:0]    numz_s6;
	logic [DEN_W-1:0]     dent_s6, denz_s6;
	logic [DIST_W-1:0]    dist_s6;
	logic                 hand_s6;
	logic [EXTRA_W-1:0]   extra_s6;

	logic                 vld_s7, tri_s7;
	logic [NUM_W-1:0]     num_s7;
	logic [DEN_W-1:0]     den_s7;
	logic [DIST_W-1:0]    dist_s7;
	logic                 hand_s7;
	logic [EXTRA_W-1:0]   extra_s7;

	logic                 vld_s8;
	logic [NUM_W-1:0]     num_s8;
	logic [DEN_W-1:0]     den_s8;
	div_pay_t             vpay_s8;

	// Divider chain.
	logic                 vc_vld [QUO_W+1];
	logic [NUM_W-1:0]     vc_rem [QUO_W+1];
	logic [DEN_W-1:0]     vc_den [QUO_W+1];
	logic [QUO_W-1:0]     vc_quo [QUO_W+1];
	logic [VPAY_W-1:0]    vc_pay [QUO_W+1];
	div_pay_t             vpo;
	logic [QUO_W-1:0]     quo;

	// Stage 9: triangular radicand and trapezoidal time.
	logic                 vld_s9;
	logic [TRAD_W-1:0]    trad_s9;
	tri_pay_t             tpay_s9;

	// Triangular square root chain.
	logic                 tc_vld  [TRT_W+1];
	logic [TRAD_W-1:0]    tc_x    [TRT_W+1];
	logic [TRT_W:0]       tc_rem  [TRT_W+1];
	logic [TRT_W-1:0]     tc_root [TRT_W+1];
	logic [TPAY_W-1:0]    tc_pay  [TRT_W+1];
	tri_pay_t             tpo;

	// Stage 10 and result.
	logic                 vld_s10;
	logic [TIME_W-1:0]    t_s10;
	logic [DIST_W-1:0]    dist_s10;
	logic                 hand_s10;
	logic [EXTRA_W-1:0]   extra_s10;
	logic [ADD_W-1:0]     tsum;
	logic [TIME_W-1:0]    t_fin;

	// Output buffer.
	logic [TIME_W-1:0]    tt_q [2];
	logic [DIST_W-1:0]    pl_q [2];

	// ------------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= SPEED_RST;
			accel_q  <= ACCEL_RST;
			decel_q  <= DECEL_RST;
			load_q   <= '0;
			unload_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SPEED:  speed_q  <= cfg_data[RATE_W-1:0];
				CFG_ACCEL:  accel_q  <= cfg_data[RATE_W-1:0];
				CFG_DECEL:  decel_q  <= cfg_data[RATE_W-1:0];
				CFG_LOAD:   load_q   <= cfg_data[DUR_W-1:0];
				CFG_UNLOAD: unload_q <= cfg_data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Flow control: the pipeline holds as a whole while the buffer is full.
	// ------------------------------------------------------------------------
	assign adv      = (cnt_q != BUF_FULL);
	assign in_stall = !adv;
	assign push     = adv && vld_s10;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= dc_vld[DIST_W];
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vc_vld[QUO_W];
			vld_s10 <= tc_vld[TRT_W];
		end
	end

	// ------------------------------------------------------------------------
	// Stages 1 to 3
	// ------------------------------------------------------------------------
	assign fa[0] = from_x;
	assign fa[1] = from_y;
	assign fa[2] = from_z;
	assign ta[0] = to_x;
	assign ta[1] = to_y;
	assign ta[2] = to_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dd[i] = (CB + 1)'(fa[i]) - (CB + 1)'(ta[i]);
			ad[i] = dd[i][CB] ? CB'(-dd[i]) : CB'(dd[i]);
		end
	end

	assign ssum = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ad_s1[i] <= ad[i];
				sq_s2[i] <= SQ_W'(ad_s1[i]) * SQ_W'(ad_s1[i]);
			end
			// A zero rate or speed counts as one.
			v_s1     <= (speed_q == '0) ? RATE_W'(1) : speed_q;
			a1_s1    <= (accel_q == '0) ? RATE_W'(1) : accel_q;
			a2_s1    <= (decel_q == '0) ? RATE_W'(1) : decel_q;
			hand_s1  <= with_handling;
			extra_s1 <= EXTRA_W'(load_q) + EXTRA_W'(unload_q);

			a1a2_s2  <= PROD_W'(a1_s1) * PROD_W'(a2_s1);
			vsq_s2   <= PROD_W'(v_s1) * PROD_W'(v_s1);
			asum_s2  <= ASUM_W'(a1_s1) + ASUM_W'(a2_s1);
			v_s2     <= v_s1;
			hand_s2  <= hand_s1;
			extra_s2 <= extra_s1;

			// The distance saturates once its square reaches the top of the
			// radicand range; the low bits then need not be exact.
			rad_s3        <= RAD_W'(ssum) << DIST_SH;
			dpay_s3.psat  <= (ssum >> PATH_SAT_SH) != '0;
			dpay_s3.a1a2  <= a1a2_s2;
			dpay_s3.asum  <= asum_s2;
			dpay_s3.rhs0  <= RHS0_W'(vsq_s2) * RHS0_W'(asum_s2);
			dpay_s3.a1a2v <= PROD3_W'(a1a2_s2) * PROD3_W'(v_s2);
			dpay_s3.hand  <= hand_s2;
			dpay_s3.extra <= extra_s2;
		end
	end

	// ------------------------------------------------------------------------
	// Distance square root chain
	// ------------------------------------------------------------------------
	assign dc_vld[0]  = vld_s3;
	assign dc_x[0]    = rad_s3;
	assign dc_rem[0]  = '0;
	assign dc_root[0] = '0;
	assign dc_pay[0]  = dpay_s3;

	for (genvar i = 0; i < DIST_W; i++) begin : g_dist
		tmt_sqrt_cell #(.RW(DIST_W), .PW(DPAY_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.vld_in  (dc_vld[i]),
			.x_in    (dc_x[i]),
			.rem_in  (dc_rem[i]),
			.root_in (dc_root[i]),
			.pay_in  (dc_pay[i]),
			.vld_s1  (dc_vld[i+1]),
			.x_s1    (dc_x[i+1]),
			.rem_s1  (dc_rem[i+1]),
			.root_s1 (dc_root[i+1]),
			.pay_s1  (dc_pay[i+1])
		);
	end

	assign dpo  = dist_pay_t'(dc_pay[DIST_W]);
	assign plen = dpo.psat ? PATH_MAX : dc_root[DIST_W];

	// ------------------------------------------------------------------------
	// Stages 4 to 8
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			lhs_s4   <= LHS_W'((LHS_W - 1)'(plen) * (LHS_W - 1)'(dpo.a1a2)) << 1;
			p2_s4    <= P2_W'((P2_W - 1)'(plen) * (P2_W - 1)'(dpo.asum)) << 1;
			rhs_s4   <= RHS_W'(dpo.rhs0) << 8;
			dist_s4  <= plen;
			a1a2_s4  <= dpo.a1a2;
			a1a2v_s4 <= dpo.a1a2v;
			hand_s4  <= dpo.hand;
			extra_s4 <= dpo.extra;

			// Triangular while the distance fits in the two ramps.
			tri_s5   <= lhs_s4 <= LHS_W'(rhs_s4);
			slr_s5   <= SLR_W'(lhs_s4) + SLR_W'(rhs_s4);
			p2_s5    <= p2_s4;
			a1a2_s5  <= a1a2_s4;
			a1a2v_s5 <= a1a2v_s4;
			dist_s5  <= dist_s4;
			hand_s5  <= hand_s4;
			extra_s5 <= extra_s4;

			numt_s6  <= NUMT_W'(p2_s5) * NUMT_W'(MS_PER_S_SQ);
			numz_s6  <= NUMZ_W'(slr_s5) * NUMZ_W'(MS_PER_S);
			dent_s6  <= DEN_W'(a1a2_s5) << 8;
			denz_s6  <= DEN_W'(a1a2v_s5) << 9;
			tri_s6   <= tri_s5;
			dist_s6  <= dist_s5;
			hand_s6  <= hand_s5;
			extra_s6 <= extra_s5;

			num_s7   <= tri_s6 ? (NUM_W'(numt_s6) << (2 * FB)) : (NUM_W'(numz_s6) << FB);
			den_s7   <= tri_s6 ? dent_s6 : denz_s6;
			tri_s7   <= tri_s6;
			dist_s7  <= dist_s6;
			hand_s7  <= hand_s6;
			extra_s7 <= extra_s6;

			num_s8         <= num_s7;
			den_s8         <= den_s7;
			vpay_s8.is_tri <= tri_s7;
			vpay_s8.tsat   <= !tri_s7 && (CMP_W'(num_s7) >= (CMP_W'(den_s7) << TIME_W));
			vpay_s8.plen   <= dist_s7;
			vpay_s8.hand   <= hand_s7;
			vpay_s8.extra  <= extra_s7;
		end
	end

	// ------------------------------------------------------------------------
	// Divider chain, most significant quotient bit first
	// ------------------------------------------------------------------------
	assign vc_vld[0] = vld_s8;
	assign vc_rem[0] = num_s8;
	assign vc_den[0] = den_s8;
	assign vc_quo[0] = '0;
	assign vc_pay[0] = vpay_s8;

	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		tmt_div_cell #(
			.NW(NUM_W), .DW(DEN_W), .QW(QUO_W), .SH(QUO_W - 1 - i), .PW(VPAY_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_in (vc_vld[i]),
			.rem_in (vc_rem[i]),
			.den_in (vc_den[i]),
			.quo_in (vc_quo[i]),
			.pay_in (vc_pay[i]),
			.vld_s1 (vc_vld[i+1]),
			.rem_s1 (vc_rem[i+1]),
			.den_s1 (vc_den[i+1]),
			.quo_s1 (vc_quo[i+1]),
			.pay_s1 (vc_pay[i+1])
		);
	end

	assign vpo = div_pay_t'(vc_pay[QUO_W]);
	assign quo = vc_quo[QUO_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			trad_s9        <= TRAD_W'(quo);
			tpay_s9.is_tri <= vpo.is_tri;
			tpay_s9.trap_t <= (vpo.tsat || (quo[QUO_W-1:TIME_W] != '0)) ?
				TIME_MAX : quo[TIME_W-1:0];
			tpay_s9.plen   <= vpo.plen;
			tpay_s9.hand   <= vpo.hand;
			tpay_s9.extra  <= vpo.extra;
		end
	end

	// ------------------------------------------------------------------------
	// Triangular-case square root chain
	// ------------------------------------------------------------------------
	assign tc_vld[0]  = vld_s9;
	assign tc_x[0]    = trad_s9;
	assign tc_rem[0]  = '0;
	assign tc_root[0] = '0;
	assign tc_pay[0]  = tpay_s9;

	for (genvar i = 0; i < TRT_W; i++) begin : g_tri
		tmt_sqrt_cell #(.RW(TRT_W), .PW(TPAY_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.vld_in  (tc_vld[i]),
			.x_in    (tc_x[i]),
			.rem_in  (tc_rem[i]),
			.root_in (tc_root[i]),
			.pay_in  (tc_pay[i]),
			.vld_s1  (tc_vld[i+1]),
			.x_s1    (tc_x[i+1]),
			.rem_s1  (tc_rem[i+1]),
			.root_s1 (tc_root[i+1]),
			.pay_s1  (tc_pay[i+1])
		);
	end

	assign tpo = tri_pay_t'(tc_pay[TRT_W]);

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s10     <= tpo.is_tri ? TIME_W'(tc_root[TRT_W]) : tpo.trap_t;
			dist_s10  <= tpo.plen;
			hand_s10  <= tpo.hand;
			extra_s10 <= tpo.extra;
		end
	end

	// Handling time in whole milliseconds, added with saturation.
	assign tsum  = ADD_W'(t_s10) + (ADD_W'(extra_s10) << FB);
	assign t_fin = !hand_s10 ? t_s10 :
		(tsum > ADD_W'(TIME_MAX)) ? TIME_MAX : tsum[TIME_W-1:0];

	// ------------------------------------------------------------------------
	// Output buffer
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			tt_q[wr_q] <= t_fin;
			pl_q[wr_q] <= dist_s10;
		end
	end

	assign out_valid   = (cnt_q != '0);
	assign travel_time = tt_q[rd_q];
	assign path_length = pl_q[rd_q];

endmodule

`default_nettype wire

// ===== hw/rtl/tmt_checker.sv =====
// ----------------------------------------------------------------------------
// Trapezoid move time checker
// Port-level checks on the handshakes of the block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trapezoid_move_time_macros.svh"

module tmt_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_stall,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic                       cfg_ready,
	input wire logic [tmt_pkg::TIME_W-1:0] travel_time,
	input wire logic [tmt_pkg::DIST_W-1:0] path_length
);

	// A result held back by the receiver stays put.
	`TMT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(travel_time) && $stable(path_length),
		"result changed while stalled")

	// A result only leaves when it is taken.
	`TMT_ASSERT_NOW(a_out_taken, $fell(out_valid), $past(!out_stall),
		"result dropped without being taken")

	// Requests are held off only while finished results are waiting.
	`TMT_ASSERT_NOW(a_stall_cause, in_stall, out_valid,
		"input stalled with no result waiting")

	// Register writes are never refused.
	`TMT_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready,
		"configuration port not ready")

endmodule

bind trapezoid_move_time tmt_checker u_tmt_checker (.*);

`default_nettype wire
